@@ rtl/tsre_pkg.sv @@
`default_nettype none

package tsre_pkg;

  // Stack geometry
  localparam int STACK_DEPTH = 512;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int PTR_SUM_W   = ADDR_W + 1;
  localparam int DATA_W      = 32;
  localparam int SIZE_W      = 10;

  // Request codes
  typedef enum logic [2:0] {
    REQ_SWAP = 3'd0,
    REQ_MOVE = 3'd1,
    REQ_ROT  = 3'd2,
    REQ_RROT = 3'd3,
    REQ_LOAD = 3'd4
  } req_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_SHORT = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Operation handed to one stack cell
  typedef enum logic [2:0] {
    OP_NONE,
    OP_PUSH,
    OP_POP,
    OP_SWAP,
    OP_ROT,
    OP_RROT
  } cell_op_t;

  typedef struct packed {
    logic [2:0]               req_type;
    logic                     stack_sel;
    logic signed [DATA_W-1:0] load_value;
  } in_word_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] top_of_a;
    logic signed [DATA_W-1:0] top_of_b;
    logic [SIZE_W-1:0]        size_of_a;
    logic [SIZE_W-1:0]        size_of_b;
    logic [1:0]               status;
  } out_word_t;

  typedef struct packed {
    cell_op_t                 op;
    logic signed [DATA_W-1:0] value;
  } cell_cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0]         count;
    logic signed [DATA_W-1:0] top;
  } cell_stat_t;

  // Circular add of an offset below the depth
  function automatic logic [ADDR_W-1:0] wrap_add(input logic [ADDR_W-1:0] base,
                                                 input logic [ADDR_W-1:0] ofs);
    logic [PTR_SUM_W-1:0] sum;
    sum = {1'b0, base} + {1'b0, ofs};
    if (sum >= PTR_SUM_W'(STACK_DEPTH)) begin
      sum = sum - PTR_SUM_W'(STACK_DEPTH);
    end
    return sum[ADDR_W-1:0];
  endfunction

endpackage

`default_nettype wire

@@ rtl/two_stack_rotate_engine.sv @@
`default_nettype none

// Two bounded stacks, A and B, of signed 32-bit words.
// Input: a request word is taken when start is high and busy is low. busy
// stays low, so a request word may be issued in every cycle. Each request
// swaps the top two, moves the other stack's top onto the selected stack,
// rotates (top to bottom), reverse rotates (bottom to top) or loads a value.
// Output: exactly one result word per request, on out_word with out_strobe
// high for one cycle; the taken request is registered in acc_r, and the
// strobe and word are then registered together. It carries both tops (zero
// for an empty stack), both sizes and a status code.
// Throughput: one request per cycle. Each stack is a cell with a ring buffer
// RAM (one read port, one write port) and its top element in a register;
// every operation needs at most one RAM read and one RAM write per stack, and
// the read-back of a new top is forwarded into the next request.
// Reset empties both stacks at once; the RAM contents are not cleared.
// The receiver cannot stall; results must be taken when strobed.

module two_stack_rotate_engine (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire tsre_pkg::in_word_t  in_word,
  output logic                     out_strobe,
  output tsre_pkg::out_word_t      out_word
);

  tsre_pkg::cell_cmd_t  cmd_a, cmd_b;
  tsre_pkg::cell_stat_t stat_a, stat_b;
  tsre_pkg::cell_stat_t dst_stat, src_stat;
  tsre_pkg::cell_op_t   dst_op, src_op;
  logic signed [tsre_pkg::DATA_W-1:0] dst_val;
  tsre_pkg::status_t    status_nxt, status_r;
  logic                 accept;
  logic                 acc_r;
  logic                 out_strobe_r;
  tsre_pkg::out_word_t  out_word_r, out_word_nxt;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign dst_stat = in_word.stack_sel ? stat_b : stat_a;
  assign src_stat = in_word.stack_sel ? stat_a : stat_b;

  // Decode the request against the current sizes
  always_comb begin
    dst_op     = tsre_pkg::OP_NONE;
    src_op     = tsre_pkg::OP_NONE;
    dst_val    = in_word.load_value;
    status_nxt = tsre_pkg::ST_DONE;
    unique case (in_word.req_type) inside
      tsre_pkg::REQ_SWAP, tsre_pkg::REQ_ROT, tsre_pkg::REQ_RROT: begin
        if (dst_stat.count < tsre_pkg::CNT_W'(2)) begin
          status_nxt = tsre_pkg::ST_SHORT;
        end else if (in_word.req_type == tsre_pkg::REQ_SWAP) begin
          dst_op = tsre_pkg::OP_SWAP;
        end else if (in_word.req_type == tsre_pkg::REQ_ROT) begin
          dst_op = tsre_pkg::OP_ROT;
        end else begin
          dst_op = tsre_pkg::OP_RROT;
        end
      end
      tsre_pkg::REQ_MOVE: begin
        dst_val = src_stat.top;
        if (src_stat.count == '0) begin
          status_nxt = tsre_pkg::ST_SHORT;
        end else if (dst_stat.count == tsre_pkg::CNT_W'(tsre_pkg::STACK_DEPTH)) begin
          status_nxt = tsre_pkg::ST_FULL;
        end else begin
          dst_op = tsre_pkg::OP_PUSH;
          src_op = tsre_pkg::OP_POP;
        end
      end
      tsre_pkg::REQ_LOAD: begin
        if (dst_stat.count == tsre_pkg::CNT_W'(tsre_pkg::STACK_DEPTH)) begin
          status_nxt = tsre_pkg::ST_FULL;
        end else begin
          dst_op = tsre_pkg::OP_PUSH;
        end
      end
      default: begin
      end
    endcase
  end

  // Route the operations to the two cells; drop them when nothing is taken
  always_comb begin
    cmd_a.op    = tsre_pkg::OP_NONE;
    cmd_b.op    = tsre_pkg::OP_NONE;
    cmd_a.value = dst_val;
    cmd_b.value = dst_val;
    if (accept) begin
      cmd_a.op = in_word.stack_sel ? src_op : dst_op;
      cmd_b.op = in_word.stack_sel ? dst_op : src_op;
    end
  end

  tsre_cell u_cell_a (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd_a),
    .stat  (stat_a)
  );

  tsre_cell u_cell_b (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd_b),
    .stat  (stat_b)
  );

  // Assemble the result word once the new tops have settled
  always_comb begin
    out_word_nxt.top_of_a  = (stat_a.count == '0) ? '0 : stat_a.top;
    out_word_nxt.top_of_b  = (stat_b.count == '0) ? '0 : stat_b.top;
    out_word_nxt.size_of_a = tsre_pkg::SIZE_W'(stat_a.count);
    out_word_nxt.size_of_b = tsre_pkg::SIZE_W'(stat_b.count);
    out_word_nxt.status    = status_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r        <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      acc_r        <= accept;
      out_strobe_r <= acc_r;
    end
  end

  // Hold status for a stage, then register the result word
  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
    end
    if (acc_r) begin
      out_word_r <= out_word_nxt;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_word   = out_word_r;

endmodule

`default_nettype wire

@@ rtl/tsre_ram.sv @@
`default_nettype none

module tsre_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port and read-first registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

@@ rtl/tsre_cell.sv @@
`default_nettype none

module tsre_cell (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire tsre_pkg::cell_cmd_t  cmd,
  output tsre_pkg::cell_stat_t      stat
);

  // The top element lives in top_r; the RAM holds the rest as a ring from base_r
  logic [tsre_pkg::ADDR_W-1:0]        base_r, base_nxt;
  logic [tsre_pkg::CNT_W-1:0]         count_r, count_nxt;
  logic signed [tsre_pkg::DATA_W-1:0] top_r, top_nxt;
  logic                               pend_r, pend_nxt;

  logic                               wr_en, rd_en;
  logic [tsre_pkg::ADDR_W-1:0]        wr_addr, rd_addr;
  logic [tsre_pkg::DATA_W-1:0]        wr_data, rd_data;
  logic signed [tsre_pkg::DATA_W-1:0] top_cur;
  logic [tsre_pkg::CNT_W-1:0]         cnt_m1, cnt_m2;
  logic [tsre_pkg::ADDR_W-1:0]        idx_m1, idx_m2;

  // Forward the word that the RAM just read back as the new top
  assign top_cur = pend_r ? $signed(rd_data) : top_r;

  assign cnt_m1 = count_r - tsre_pkg::CNT_W'(1);
  assign cnt_m2 = count_r - tsre_pkg::CNT_W'(2);
  assign idx_m1 = tsre_pkg::wrap_add(base_r, cnt_m1[tsre_pkg::ADDR_W-1:0]);
  assign idx_m2 = tsre_pkg::wrap_add(base_r, cnt_m2[tsre_pkg::ADDR_W-1:0]);

  // Decode the operation into pointer moves and one RAM read and write
  always_comb begin
    base_nxt  = base_r;
    count_nxt = count_r;
    top_nxt   = top_cur;
    pend_nxt  = 1'b0;
    wr_en     = 1'b0;
    wr_addr   = idx_m1;
    wr_data   = top_cur;
    rd_en     = 1'b0;
    rd_addr   = idx_m2;
    unique case (cmd.op)
      tsre_pkg::OP_PUSH: begin
        wr_en     = (count_r != '0);
        top_nxt   = cmd.value;
        count_nxt = count_r + tsre_pkg::CNT_W'(1);
      end
      tsre_pkg::OP_POP: begin
        rd_en     = (count_r > tsre_pkg::CNT_W'(1));
        pend_nxt  = rd_en;
        count_nxt = cnt_m1;
      end
      tsre_pkg::OP_SWAP: begin
        rd_en    = 1'b1;
        pend_nxt = 1'b1;
        wr_en    = 1'b1;
        wr_addr  = idx_m2;
      end
      tsre_pkg::OP_ROT: begin
        rd_en    = 1'b1;
        pend_nxt = 1'b1;
        wr_en    = 1'b1;
        wr_addr  = tsre_pkg::wrap_add(base_r,
                                      tsre_pkg::ADDR_W'(tsre_pkg::STACK_DEPTH - 1));
        base_nxt = wr_addr;
      end
      tsre_pkg::OP_RROT: begin
        rd_en    = 1'b1;
        rd_addr  = base_r;
        pend_nxt = 1'b1;
        wr_en    = 1'b1;
        base_nxt = tsre_pkg::wrap_add(base_r, tsre_pkg::ADDR_W'(1));
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r  <= '0;
      count_r <= '0;
      pend_r  <= 1'b0;
    end else begin
      base_r  <= base_nxt;
      count_r <= count_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    top_r <= top_nxt;
  end

  tsre_ram #(
    .WIDTH (tsre_pkg::DATA_W),
    .DEPTH (tsre_pkg::STACK_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign stat.count = count_r;
  assign stat.top   = top_cur;

endmodule

`default_nettype wire
